### hw/rtl/user_quota_table_macros.svh
// Assertion helpers for the user quota table.
`ifndef USER_QUOTA_TABLE_MACROS_SVH
`define USER_QUOTA_TABLE_MACROS_SVH

// same-cycle implication
`define UQT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UQT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/uqt_pkg.sv
`default_nettype none

package uqt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int ACT_W   = 3;
  localparam int USER_W  = 31;
  localparam int AMT_W   = 31;
  localparam int CAT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 32;
  localparam int DATA_W  = 48;
  localparam int ENTRY_W = USER_W + AMT_W;
  localparam int NUM_CAT = 3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CAT_W-1:0] CAT_LAST = CAT_W'(NUM_CAT - 1);

  localparam logic [ACT_W-1:0] ACT_REGISTER  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_AUTHORIZE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NODATA = 2'd1;
  localparam logic [STAT_W-1:0] ST_FAIL   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [USER_W-1:0] user_id;
    logic [AMT_W-1:0]  amount;
    logic [CAT_W-1:0]  category;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CAT_W-1:0]  stat_category;
    logic [CNT_W-1:0]  request_count;
    logic [DATA_W-1:0] data_total;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic             clear;
    logic             count;
    logic [CAT_W-1:0] cat;
    logic [AMT_W-1:0] amount;
  } tot_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  request_count;
    logic [DATA_W-1:0] data_total;
  } tot_view_t;

endpackage

`default_nettype wire

### hw/rtl/uqt_ram.sv
`default_nettype none

module uqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/uqt_totals.sv
`default_nettype none

module uqt_totals (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire uqt_pkg::tot_cmd_t             cmd,
  input  wire logic [uqt_pkg::CAT_W-1:0]     rd_cat,
  output uqt_pkg::tot_view_t                 view
);

  logic [uqt_pkg::CNT_W-1:0]  req_cnt  [uqt_pkg::NUM_CAT];
  logic [uqt_pkg::DATA_W-1:0] data_sum [uqt_pkg::NUM_CAT];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < uqt_pkg::NUM_CAT; i++) begin
        req_cnt[i]  <= '0;
        data_sum[i] <= '0;
      end
    end else if (cmd.count && cmd.cat <= uqt_pkg::CAT_LAST) begin
      req_cnt[cmd.cat]  <= req_cnt[cmd.cat] + 1'b1;
      data_sum[cmd.cat] <= data_sum[cmd.cat] +
                           {{(uqt_pkg::DATA_W - uqt_pkg::AMT_W){1'b0}}, cmd.amount};
    end
  end

  always_comb begin
    if (rd_cat <= uqt_pkg::CAT_LAST) begin
      view.request_count = req_cnt[rd_cat];
      view.data_total    = data_sum[rd_cat];
    end else begin
      view = '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/uqt_ctrl.sv
`default_nettype none

module uqt_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire uqt_pkg::req_t                  req,
  output logic                                busy,
  output uqt_pkg::rsp_t                       rsp,
  output logic                                rsp_valid,
  output logic [uqt_pkg::IDX_W-1:0]           ram_raddr,
  input  wire logic [uqt_pkg::ENTRY_W-1:0]    ram_rdata,
  output logic                                ram_we,
  output logic [uqt_pkg::IDX_W-1:0]           ram_waddr,
  output logic [uqt_pkg::ENTRY_W-1:0]         ram_wdata,
  output uqt_pkg::tot_cmd_t                   tot_cmd,
  output logic [uqt_pkg::CAT_W-1:0]           tot_rd_cat,
  input  wire uqt_pkg::tot_view_t             tot_view
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                            state;
  uqt_pkg::req_t                     cur;
  logic [uqt_pkg::IDX_W-1:0]         idx;
  logic [uqt_pkg::IDX_W-1:0]         cmp_idx;
  logic                              cmp_vld;
  logic [uqt_pkg::IDX_W-1:0]         hit_idx;
  logic [uqt_pkg::AMT_W-1:0]         quota;
  logic [uqt_pkg::CAT_W-1:0]         emit_cat;
  logic [uqt_pkg::TABLE_ENTRIES-1:0] entry_valid;

  logic                              accept;
  logic                              is_reg;
  logic                              hit;
  logic                              under;
  logic [uqt_pkg::AMT_W-1:0]         quota_new;
  logic [uqt_pkg::USER_W-1:0]        rd_user;
  logic [uqt_pkg::AMT_W-1:0]         rd_quota;

  function automatic uqt_pkg::rsp_t status_rsp(logic [uqt_pkg::STAT_W-1:0] st);
    uqt_pkg::rsp_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign is_reg   = (cur.action == uqt_pkg::ACT_REGISTER);
  assign rd_user  = ram_rdata[uqt_pkg::ENTRY_W-1:uqt_pkg::AMT_W];
  assign rd_quota = ram_rdata[uqt_pkg::AMT_W-1:0];

  assign hit = cmp_vld && (is_reg ? !entry_valid[cmp_idx]
                                  : (entry_valid[cmp_idx] && rd_user == cur.user_id));

  assign under     = (quota < cur.amount);
  assign quota_new = under ? '0 : (quota - cur.amount);

  assign ram_raddr = idx;
  assign ram_we    = ((state == S_SCAN) && hit && is_reg) || (state == S_UPD);
  assign ram_waddr = (state == S_UPD) ? hit_idx : cmp_idx;
  assign ram_wdata = (state == S_UPD) ? {cur.user_id, quota_new}
                                      : {cur.user_id, cur.amount};

  assign tot_cmd.clear  = accept && (req.action == uqt_pkg::ACT_CLEAR);
  assign tot_cmd.count  = (state == S_UPD);
  assign tot_cmd.cat    = cur.category;
  assign tot_cmd.amount = cur.amount;
  assign tot_rd_cat     = emit_cat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      cmp_vld     <= 1'b0;
      entry_valid <= '0;
    end else begin
      rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur      <= req;
            idx      <= '0;
            cmp_vld  <= 1'b0;
            emit_cat <= '0;
            case (req.action)
              uqt_pkg::ACT_REGISTER, uqt_pkg::ACT_DELETE: begin
                state <= S_SCAN;
              end
              uqt_pkg::ACT_AUTHORIZE: begin
                if (req.category <= uqt_pkg::CAT_LAST) begin
                  state <= S_SCAN;
                end else begin
                  rsp       <= status_rsp(uqt_pkg::ST_FAIL);
                  rsp_valid <= 1'b1;
                end
              end
              uqt_pkg::ACT_CLEAR: begin
                rsp       <= status_rsp(uqt_pkg::ST_OK);
                rsp_valid <= 1'b1;
              end
              uqt_pkg::ACT_READ: begin
                state <= S_EMIT;
              end
              default: begin
                rsp       <= status_rsp(uqt_pkg::ST_FAIL);
                rsp_valid <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_vld <= 1'b1;
          cmp_idx <= idx;
          if (idx != uqt_pkg::IDX_LAST) begin
            idx <= idx + 1'b1;
          end
          if (hit) begin
            cmp_vld <= 1'b0;
            case (cur.action)
              uqt_pkg::ACT_REGISTER: begin
                entry_valid[cmp_idx] <= 1'b1;
                rsp       <= status_rsp(uqt_pkg::ST_OK);
                rsp_valid <= 1'b1;
                state     <= S_IDLE;
              end
              uqt_pkg::ACT_DELETE: begin
                entry_valid[cmp_idx] <= 1'b0;
                rsp       <= status_rsp(uqt_pkg::ST_OK);
                rsp_valid <= 1'b1;
                state     <= S_IDLE;
              end
              default: begin
                hit_idx <= cmp_idx;
                quota   <= rd_quota;
                state   <= S_UPD;
              end
            endcase
          end else if (cmp_vld && cmp_idx == uqt_pkg::IDX_LAST) begin
            cmp_vld   <= 1'b0;
            rsp       <= status_rsp(uqt_pkg::ST_FAIL);
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_UPD: begin
          rsp       <= status_rsp(under ? uqt_pkg::ST_NODATA : uqt_pkg::ST_OK);
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_EMIT: begin
          rsp.status        <= uqt_pkg::ST_OK;
          rsp.stat_category <= emit_cat;
          rsp.request_count <= tot_view.request_count;
          rsp.data_total    <= tot_view.data_total;
          rsp.last          <= (emit_cat == uqt_pkg::CAT_LAST);
          rsp_valid         <= 1'b1;
          emit_cat          <= emit_cat + 1'b1;
          if (emit_cat == uqt_pkg::CAT_LAST) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/user_quota_table.sv
// User quota table.
// Request channel: drive req and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy stays high while a
// request is being worked on.
// Result channel: each result sits on rsp for one cycle, marked by rsp_valid,
// and must be taken in that cycle; there is no way to hold results off.
// Read gives three results on consecutive cycles (categories 0, 1, 2, last on
// the third); every other action gives one.
// Register, delete and authorize walk the table one entry per cycle through a
// RAM with one write port and one registered read port, and one shared compare;
// the walk stops at the match or free slot, so the result comes sooner when it
// is near the start of the table, and authorize then passes a quota update
// state. Reset totals, undefined actions and authorize with a bad category
// answer on the next cycle; read answers from its emit state. A new request may
// be given in the cycle the final result shows.
// Reset empties the table and clears the category totals at once; no sweep.
`default_nettype none

`include "user_quota_table_macros.svh"

module user_quota_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire uqt_pkg::req_t req,
  output logic               busy,
  output uqt_pkg::rsp_t      rsp,
  output logic               rsp_valid
);

  logic [uqt_pkg::IDX_W-1:0]   ram_raddr;
  logic [uqt_pkg::IDX_W-1:0]   ram_waddr;
  logic [uqt_pkg::ENTRY_W-1:0] ram_rdata;
  logic [uqt_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        ram_we;
  uqt_pkg::tot_cmd_t           tot_cmd;
  uqt_pkg::tot_view_t          tot_view;
  logic [uqt_pkg::CAT_W-1:0]   tot_rd_cat;

  uqt_ram #(
    .WIDTH (uqt_pkg::ENTRY_W),
    .DEPTH (uqt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  uqt_totals u_totals (
    .clk    (clk),
    .rst    (rst),
    .cmd    (tot_cmd),
    .rd_cat (tot_rd_cat),
    .view   (tot_view)
  );

  uqt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .tot_cmd    (tot_cmd),
    .tot_rd_cat (tot_rd_cat),
    .tot_view   (tot_view)
  );

  `UQT_ASSERT_NEXT(a_read_burst, rsp_valid && !rsp.last, rsp_valid, "read burst broken")
  `UQT_ASSERT_NOW(a_busy_pending, rsp_valid && !rsp.last, busy, "idle with results pending")
  `UQT_ASSERT_NEXT(a_accept_acts, start && !busy, busy || rsp_valid, "request dropped")
  `UQT_ASSERT_NOW(a_cat_on_read, rsp_valid && rsp.stat_category != 2'd0,
                  rsp.status == uqt_pkg::ST_OK, "bad status on totals")

endmodule

`default_nettype wire

### tb/sv/user_quota_table_checker.sv
`default_nettype none

module user_quota_table_checker
  import uqt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic busy,
  input  wire req_t req,
  input  wire rsp_t rsp,
  input  wire logic rsp_valid,
  output int        mismatches,
  output int        rsp_pending,
  output int        reqs_taken
);

  logic              slot_used  [TABLE_ENTRIES];
  logic [USER_W-1:0] slot_user  [TABLE_ENTRIES];
  logic [AMT_W-1:0]  slot_left  [TABLE_ENTRIES];
  logic [CNT_W-1:0]  cat_reqs   [NUM_CAT];
  logic [DATA_W-1:0] cat_data   [NUM_CAT];
  rsp_t              rsp_due    [$];

  function automatic int find_user(logic [USER_W-1:0] uid);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i] && slot_user[i] == uid) return i;
    end
    return -1;
  endfunction

  task automatic clear_totals();
    for (int c = 0; c < NUM_CAT; c++) begin
      cat_reqs[c] = '0;
      cat_data[c] = '0;
    end
  endtask

  task automatic apply_request(req_t r);
    int   idx;
    rsp_t res;
    res        = '0;
    res.status = ST_FAIL;
    res.last   = 1'b1;
    idx        = -1;
    case (r.action)
      ACT_REGISTER: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!slot_used[i] && idx < 0) idx = i;
        end
        if (idx >= 0) begin
          slot_used[idx]  = 1'b1;
          slot_user[idx]  = r.user_id;
          slot_left[idx]  = r.amount;
          res.status      = ST_OK;
        end
      end
      ACT_AUTHORIZE: begin
        if (r.category < NUM_CAT) idx = find_user(r.user_id);
        if (idx >= 0) begin
          cat_reqs[r.category] = cat_reqs[r.category] + 1'b1;
          cat_data[r.category] = cat_data[r.category] + DATA_W'(r.amount);
          if (slot_left[idx] < r.amount) begin
            slot_left[idx] = '0;
            res.status     = ST_NODATA;
          end else begin
            slot_left[idx] = slot_left[idx] - r.amount;
            res.status     = ST_OK;
          end
        end
      end
      ACT_DELETE: begin
        idx = find_user(r.user_id);
        if (idx >= 0) begin
          slot_used[idx]  = 1'b0;
          slot_left[idx]  = '0;
          res.status      = ST_OK;
        end
      end
      ACT_CLEAR: begin
        clear_totals();
        res.status = ST_OK;
      end
      default: ;
    endcase
    if (r.action == ACT_READ) begin
      for (int c = 0; c < NUM_CAT; c++) begin
        res.status        = ST_OK;
        res.stat_category = CAT_W'(c);
        res.request_count = cat_reqs[c];
        res.data_total    = cat_data[c];
        res.last          = (c == NUM_CAT - 1);
        rsp_due.push_back(res);
      end
    end else begin
      rsp_due.push_back(res);
    end
  endtask

  task automatic check_rsp(rsp_t got);
    rsp_t want;
    if (rsp_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: status %0d cat %0d count %0d data %0d last %0d",
                 got.status, got.stat_category, got.request_count, got.data_total,
                 got.last);
    end else begin
      want = rsp_due.pop_front();
      if (got.status !== want.status || got.stat_category !== want.stat_category ||
          got.request_count !== want.request_count ||
          got.data_total !== want.data_total || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result mismatch (expected/actual): status %0d/%0d cat %0d/%0d ",
                 want.status, got.status, want.stat_category, got.stat_category);
          $display("count %0d/%0d data %0d/%0d last %0d/%0d",
                   want.request_count, got.request_count, want.data_total,
                   got.data_total, want.last, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_used[i]  = 1'b0;
        slot_user[i]  = '0;
        slot_left[i]  = '0;
      end
      clear_totals();
      rsp_due.delete();
      mismatches = 0;
      reqs_taken = 0;
    end else begin
      if (rsp_valid) check_rsp(rsp);
      if (start && !busy) begin
        apply_request(req);
        reqs_taken++;
      end
    end
    rsp_pending = rsp_due.size();
  end

endmodule

`default_nettype wire

### tb/sv/user_quota_table_tb.sv
`default_nettype none

module user_quota_table_tb;
  import uqt_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 8;
  localparam int RANDOM_REQS  = 420;

  localparam logic [CAT_W-1:0] CAT_VIDEO  = 2'd0;
  localparam logic [CAT_W-1:0] CAT_MUSIC  = 2'd1;
  localparam logic [CAT_W-1:0] CAT_SOCIAL = 2'd2;
  localparam logic [CAT_W-1:0] CAT_BAD    = CAT_W'(NUM_CAT);

  localparam logic [USER_W-1:0] ID_MAX  = '1;
  localparam logic [AMT_W-1:0]  AMT_MAX = '1;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic rsp_valid;
  req_t req;
  rsp_t rsp;
  int   mismatches;
  int   rsp_pending;
  int   reqs_taken;
  int   cycles;

  logic [USER_W-1:0] known_ids [$];

  user_quota_table uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

  user_quota_table_checker chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .rsp         (rsp),
    .rsp_valid   (rsp_valid),
    .mismatches  (mismatches),
    .rsp_pending (rsp_pending),
    .reqs_taken  (reqs_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [USER_W-1:0] rand_id();
    return USER_W'($urandom);
  endfunction

  function automatic logic [AMT_W-1:0] rand_amt();
    return AMT_W'($urandom);
  endfunction

  function automatic int draw_gap(int n);
    if ((n / 32) % 3 == 2) return 0;
    return $urandom_range(0, 8);
  endfunction

  task automatic send(logic [ACT_W-1:0] act, logic [USER_W-1:0] uid,
                      logic [AMT_W-1:0] amt, logic [CAT_W-1:0] cat, int gap);
    int seen;
    if (gap > 0) begin
      start <= 1'b0;
      req   <= '{action: ACT_W'($urandom), user_id: rand_id(), amount: rand_amt(),
                 category: CAT_W'($urandom)};
      repeat (gap) @(negedge clk);
    end
    seen  = reqs_taken;
    start <= 1'b1;
    req   <= '{action: act, user_id: uid, amount: amt, category: cat};
    do @(negedge clk); while (reqs_taken == seen);
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("user_quota_table_tb NOT OK");
    $finish;
  end

  initial begin
    int                n;
    int                pick;
    int                reg_cut;
    int                auth_cut;
    int                del_cut;
    int                idx;
    logic [ACT_W-1:0]  act;
    logic [USER_W-1:0] uid;
    logic [AMT_W-1:0]  amt;
    logic [CAT_W-1:0]  cat;

    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    send(ACT_READ, rand_id(), rand_amt(), CAT_W'($urandom), draw_gap(0));
    send(ACT_AUTHORIZE, USER_W'(7), AMT_W'(1), CAT_VIDEO, draw_gap(0));
    send(ACT_DELETE, USER_W'(7), rand_amt(), CAT_MUSIC, draw_gap(0));
    send(ACT_REGISTER, ID_MAX, AMT_MAX, CAT_SOCIAL, draw_gap(0));
    send(ACT_REGISTER, '0, AMT_W'(100), CAT_VIDEO, draw_gap(0));
    send(ACT_REGISTER, USER_W'(5), '0, CAT_BAD, draw_gap(0));
    send(ACT_AUTHORIZE, '0, AMT_W'(40), CAT_VIDEO, draw_gap(0));
    send(ACT_AUTHORIZE, '0, AMT_W'(60), CAT_MUSIC, draw_gap(0));
    send(ACT_AUTHORIZE, '0, AMT_W'(1), CAT_SOCIAL, draw_gap(0));
    send(ACT_AUTHORIZE, ID_MAX, AMT_MAX, CAT_SOCIAL, draw_gap(0));
    send(ACT_AUTHORIZE, USER_W'(5), '0, CAT_VIDEO, draw_gap(0));
    send(ACT_AUTHORIZE, USER_W'(5), AMT_W'(3), CAT_BAD, draw_gap(0));
    send(ACT_REGISTER, '0, AMT_W'(7), CAT_MUSIC, draw_gap(0));
    send(ACT_DELETE, '0, rand_amt(), CAT_BAD, draw_gap(0));
    send(ACT_AUTHORIZE, '0, AMT_W'(7), CAT_MUSIC, draw_gap(0));
    send(ACT_READ, rand_id(), rand_amt(), CAT_W'($urandom), draw_gap(0));
    send(ACT_READ + 1'b1, rand_id(), rand_amt(), CAT_W'($urandom), draw_gap(0));
    send(ACT_READ + 2'd2, rand_id(), rand_amt(), CAT_W'($urandom), draw_gap(0));
    send(ACT_READ + 2'd3, rand_id(), rand_amt(), CAT_W'($urandom), draw_gap(0));
    send(ACT_CLEAR, rand_id(), rand_amt(), CAT_W'($urandom), draw_gap(0));
    send(ACT_READ, rand_id(), rand_amt(), CAT_W'($urandom), draw_gap(0));
    send(ACT_DELETE, ID_MAX, rand_amt(), CAT_VIDEO, draw_gap(0));
    send(ACT_REGISTER, USER_W'(42), AMT_W'(9), CAT_BAD, draw_gap(0));
    send(ACT_DELETE, USER_W'(5), rand_amt(), CAT_SOCIAL, draw_gap(0));

    // fill the table in one phase, drain it in the next
    for (n = 0; n < RANDOM_REQS; n++) begin
      if ((n / 70) % 2 == 0) begin
        reg_cut  = 30;
        auth_cut = 65;
        del_cut  = 78;
      end else begin
        reg_cut  = 8;
        auth_cut = 45;
        del_cut  = 75;
      end
      pick = $urandom_range(0, 99);
      cat  = CAT_W'($urandom_range(0, NUM_CAT - 1));
      if ($urandom_range(0, 19) == 0) cat = CAT_BAD;
      amt = rand_amt();
      uid = rand_id();
      if (known_ids.size() > 0 && $urandom_range(0, 9) != 0)
        uid = known_ids[$urandom_range(0, known_ids.size() - 1)];
      if (pick < reg_cut) begin
        act = ACT_REGISTER;
        cat = CAT_W'($urandom);
        if ($urandom_range(0, 1) == 0) uid = USER_W'($urandom_range(0, 63));
        else uid = rand_id();
        case ($urandom_range(0, 3))
          0:       amt = rand_amt();
          1:       amt = '0;
          default: amt = AMT_W'($urandom_range(0, 500));
        endcase
        if (known_ids.size() < 40) known_ids.push_back(uid);
      end else if (pick < auth_cut) begin
        act = ACT_AUTHORIZE;
        case ($urandom_range(0, 7))
          0:       amt = rand_amt();
          1:       amt = AMT_MAX;
          default: amt = AMT_W'($urandom_range(0, 200));
        endcase
      end else if (pick < del_cut) begin
        act = ACT_DELETE;
        if (known_ids.size() > 0 && $urandom_range(0, 6) != 0) begin
          idx = $urandom_range(0, known_ids.size() - 1);
          uid = known_ids[idx];
          known_ids.delete(idx);
        end
      end else if (pick < 80) begin
        act = ACT_CLEAR;
      end else if (pick < 95) begin
        act = ACT_READ;
      end else begin
        act = ACT_READ + ACT_W'($urandom_range(1, 3));
      end
      send(act, uid, amt, cat, draw_gap(n));
    end
    start <= 1'b0;

    while (rsp_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && rsp_pending == 0) begin
      $display("user_quota_table_tb OK");
    end else begin
      $display("user_quota_table_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/uqt_pkg.sv
hw/rtl/uqt_ram.sv
hw/rtl/uqt_totals.sv
hw/rtl/uqt_ctrl.sv
hw/rtl/user_quota_table.sv
tb/sv/user_quota_table_checker.sv
tb/sv/user_quota_table_tb.sv
